// ===== hw/rtl/memory_test_pattern_engine_macros.svh =====
// Assertion macros for the memory test pattern engine.
// Used by the top level only; relies on clk and arst_n being in scope.
`ifndef MEMORY_TEST_PATTERN_ENGINE_MACROS_SVH
`define MEMORY_TEST_PATTERN_ENGINE_MACROS_SVH

// Same-cycle implication, quiet while reset is asserted
`define MTPE_ASSERT_NOW(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |-> (cons)) \
		else $error(msg);

// Next-cycle implication, quiet while reset is asserted
`define MTPE_ASSERT_NEXT(lbl, ante, cons, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) (ante) |=> (cons)) \
		else $error(msg);

`endif

// ===== hw/rtl/mtpe_pkg.sv =====
// Shared types, codes and helpers for the memory test pattern engine.
// No dependencies; used by mtpe_step and memory_test_pattern_engine.
package mtpe_pkg;

	// Pattern kinds
	localparam logic [1:0] KIND_FIXED = 2'd0;
	localparam logic [1:0] KIND_INCR  = 2'd1;
	localparam logic [1:0] KIND_ANTI  = 2'd2;

	// Width codes
	localparam logic [1:0] WC_BYTE1 = 2'd0;
	localparam logic [1:0] WC_BYTE2 = 2'd1;
	localparam logic [1:0] WC_BYTE4 = 2'd2;
	localparam logic [1:0] WC_BAD   = 2'd3;

	// Step functions
	localparam logic FUNC_WRITE = 1'b0;
	localparam logic FUNC_CHECK = 1'b1;

	// Register indexes on the config port
	localparam int unsigned REG_IDX_W = 3;
	localparam logic [REG_IDX_W-1:0] REG_SEED  = 3'd0;
	localparam logic [REG_IDX_W-1:0] REG_KIND  = 3'd1;
	localparam logic [REG_IDX_W-1:0] REG_WCODE = 3'd2;
	localparam logic [REG_IDX_W-1:0] REG_RCODE = 3'd3;
	localparam logic [REG_IDX_W-1:0] REG_BASE  = 3'd4;

	typedef struct packed {
		logic [31:0] seed;
		logic [1:0]  kind;
		logic [1:0]  wcode;
		logic [1:0]  rcode;
		logic [31:0] base;
	} cfg_t;

	typedef struct packed {
		logic [31:0] counter;
		logic [31:0] held;
		logic [1:0]  piece;
		logic [31:0] unit_index;
		logic        fail;
	} state_t;

	typedef struct packed {
		logic [31:0] unit_address;
		logic [31:0] pattern_value;
		logic        mismatch;
		logic        pass_failed;
		logic        width_error;
	} result_t;

	// Value mask for a width code (invalid code keeps all bits)
	function automatic logic [31:0] width_mask(input logic [1:0] code);
		logic [31:0] m;
		unique case (code)
			WC_BYTE1: m = 32'h0000_00FF;
			WC_BYTE2: m = 32'h0000_FFFF;
			default:  m = 32'hFFFF_FFFF;
		endcase
		return m;
	endfunction

endpackage

// ===== hw/rtl/memory_test_pattern_engine.sv =====
// Memory test pattern engine: generates write data and checks read data.
// Depends on mtpe_pkg, mtpe_step and memory_test_pattern_engine_macros.svh.
//
// Each input beat is a write-pass or check-pass step and produces exactly one
// output beat with the unit address, the pattern value and the check flags.
// A beat is captured in an input register, the step logic runs in the next
// cycle against the engine state and lands in the output register, and one
// beat is taken every cycle while the output side keeps up; the single step
// stage with its state update sets that rate.
// Configuration registers are written through cfg_we/cfg_index/cfg_wdata and
// must only change while no beat is in flight.
`include "memory_test_pattern_engine_macros.svh"

module memory_test_pattern_engine (
	input  logic                             clk,
	input  logic                             arst_n,
	// config write port
	input  logic                             cfg_we,
	input  logic [mtpe_pkg::REG_IDX_W-1:0]   cfg_index,
	input  logic [31:0]                      cfg_wdata,
	// input stream
	input  logic                             s_axis_tvalid,
	output logic                             s_axis_tready,
	input  logic [31:0]                      s_axis_tdata,  // [31:0] read_data
	input  logic [1:0]                       s_axis_tuser,  // [0] func, [1] first_item
	input  logic                             s_axis_tlast,  // last_item
	// result stream
	output logic                             m_axis_tvalid,
	input  logic                             m_axis_tready,
	// [31:0] unit_address, [63:32] pattern_value, [64] mismatch,
	// [65] pass_failed, [66] width_error, [71:67] zero
	output logic [71:0]                      m_axis_tdata,
	output logic                             m_axis_tlast   // end_of_pass
);
	import mtpe_pkg::*;

	cfg_t        cfg_q;
	state_t      state_q;
	state_t      state_nxt;
	result_t     step_res;

	logic        valid_s1;
	logic        func_s1;
	logic        first_s1;
	logic        last_s1;
	logic [31:0] rdata_s1;
	logic        adv_s1;

	logic        out_valid_q;
	result_t     out_res_q;
	logic        out_last_q;

	// Configuration registers
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			cfg_q.seed  <= '0;
			cfg_q.kind  <= KIND_INCR;
			cfg_q.wcode <= WC_BYTE4;
			cfg_q.rcode <= WC_BYTE4;
			cfg_q.base  <= '0;
		end else if (cfg_we) begin
			unique case (cfg_index)
				REG_SEED:  cfg_q.seed  <= cfg_wdata;
				REG_KIND:  cfg_q.kind  <= cfg_wdata[1:0];
				REG_WCODE: cfg_q.wcode <= cfg_wdata[1:0];
				REG_RCODE: cfg_q.rcode <= cfg_wdata[1:0];
				REG_BASE:  cfg_q.base  <= cfg_wdata;
				default:   ;
			endcase
		end
	end

	// Stage 1 moves on when the output register is free or being drained
	assign adv_s1        = valid_s1 && (!out_valid_q || m_axis_tready);
	assign s_axis_tready = !valid_s1 || adv_s1;

	// Input register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (s_axis_tready) begin
			valid_s1 <= s_axis_tvalid;
		end
	end

	always_ff @(posedge clk) begin
		if (s_axis_tready && s_axis_tvalid) begin
			func_s1  <= s_axis_tuser[0];
			first_s1 <= s_axis_tuser[1];
			last_s1  <= s_axis_tlast;
			rdata_s1 <= s_axis_tdata;
		end
	end

	// Step logic
	mtpe_step u_step (
		.cfg        (cfg_q),
		.state_cur  (state_q),
		.func       (func_s1),
		.first_item (first_s1),
		.read_data  (rdata_s1),
		.res        (step_res),
		.state_nxt  (state_nxt)
	);

	// Engine state advances once per stepped beat
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			state_q <= '0;
		end else if (adv_s1) begin
			state_q <= state_nxt;
		end
	end

	// Output register
	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid_q <= 1'b0;
		end else if (adv_s1) begin
			out_valid_q <= 1'b1;
		end else if (m_axis_tready) begin
			out_valid_q <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (adv_s1) begin
			out_res_q  <= step_res;
			out_last_q <= last_s1;
		end
	end

	assign m_axis_tvalid = out_valid_q;
	assign m_axis_tlast  = out_last_q;
	assign m_axis_tdata  = {5'd0, out_res_q.width_error, out_res_q.pass_failed,
		out_res_q.mismatch, out_res_q.pattern_value, out_res_q.unit_address};

	// Checks
	`MTPE_ASSERT_NOW(a_werr_zero, out_valid_q && out_res_q.width_error, out_res_q.unit_address == 32'd0 && out_res_q.pattern_value == 32'd0 && !out_res_q.mismatch, "width error beat carries data")
	`MTPE_ASSERT_NOW(a_mism_fail, out_valid_q && out_res_q.mismatch, out_res_q.pass_failed, "mismatch without sticky fail")
	`MTPE_ASSERT_NEXT(a_fail_kept, adv_s1 && step_res.mismatch, state_q.fail, "fail flag not recorded")
	`MTPE_ASSERT_NEXT(a_s1_hold, valid_s1 && !adv_s1, valid_s1, "stalled step lost")

endmodule

// ===== hw/rtl/mtpe_step.sv =====
// One step of the pattern engine: result and next state from the current state.
// Purely combinational; depends on mtpe_pkg.
module mtpe_step (
	input  mtpe_pkg::cfg_t    cfg,
	input  mtpe_pkg::state_t  state_cur,
	input  logic              func,
	input  logic              first_item,
	input  logic [31:0]       read_data,
	output mtpe_pkg::result_t res,
	output mtpe_pkg::state_t  state_nxt
);
	import mtpe_pkg::*;

	state_t      st;
	logic        incr;
	logic        anti;
	logic        werr;
	logic [31:0] wm;
	logic [31:0] rm;
	logic [31:0] c;
	logic [31:0] c_inc;
	logic [31:0] v0, v1, v2, v3;
	logic [1:0]  p_max;
	logic [1:0]  p;
	logic [31:0] held_new;
	logic [31:0] val;
	logic        mism;
	logic [1:0]  ucode;

	// Restart applied ahead of the step
	always_comb begin
		st = state_cur;
		if (first_item) begin
			st.unit_index = '0;
			st.fail       = 1'b0;
			st.piece      = '0;
			st.held       = '0;
			st.counter    = cfg.seed & width_mask(cfg.wcode);
		end
	end

	assign incr  = (cfg.kind == KIND_INCR);
	assign anti  = (cfg.kind == KIND_ANTI);
	assign werr  = (cfg.wcode == WC_BAD) ||
		((func == FUNC_CHECK) && !anti && (cfg.rcode == WC_BAD));
	assign wm    = width_mask(cfg.wcode);
	assign rm    = width_mask(cfg.rcode);
	assign c     = st.counter & wm;
	assign c_inc = (c + 32'd1) & wm;

	// Lane values when packing several write units into one read unit
	assign v0 = incr ? c           : cfg.seed;
	assign v1 = incr ? c + 32'd1   : cfg.seed;
	assign v2 = incr ? c + 32'd2   : cfg.seed;
	assign v3 = incr ? c + 32'd3   : cfg.seed;

	// Piece selection when splitting a write unit into read units
	assign p_max    = (cfg.wcode - cfg.rcode == 2'd1) ? 2'd1 : 2'd3;
	assign p        = (st.piece > p_max) ? 2'd0 : st.piece;
	assign held_new = (p == 2'd0) ? (incr ? c : (cfg.seed & wm)) : st.held;

	// Pattern value, compare and state update
	always_comb begin
		state_nxt = st;
		val       = '0;
		mism      = 1'b0;
		ucode     = cfg.wcode;
		if (werr) begin
			val = '0;
		end else if (func == FUNC_WRITE) begin
			val = anti ? {24'd0, ~c[7:0]} : c;
			if (incr || anti) begin
				state_nxt.counter = c_inc;
			end
		end else if (anti) begin
			val               = {24'd0, ~c[7:0]};
			state_nxt.counter = c_inc;
			mism              = ((read_data & wm) != val);
		end else begin
			ucode = cfg.rcode;
			if (cfg.wcode > cfg.rcode) begin
				// wide write unit checked piece by piece, little-endian
				state_nxt.held  = held_new;
				state_nxt.piece = (p == p_max) ? 2'd0 : p + 2'd1;
				if ((p == 2'd0) && incr) begin
					state_nxt.counter = c_inc;
				end
				if (cfg.rcode == WC_BYTE1) begin
					val = {24'd0, held_new[{p, 3'b000} +: 8]};
				end else begin
					val = {16'd0, held_new[{p[0], 4'b0000} +: 16]};
				end
			end else if (cfg.wcode < cfg.rcode) begin
				// narrow write units packed into one read unit
				unique case ({cfg.wcode, cfg.rcode})
					{WC_BYTE1, WC_BYTE2}: val = {16'd0, v1[7:0], v0[7:0]};
					{WC_BYTE1, WC_BYTE4}: val = {v3[7:0], v2[7:0], v1[7:0], v0[7:0]};
					{WC_BYTE2, WC_BYTE4}: val = {v1[15:0], v0[15:0]};
					default:              val = '0;
				endcase
				if (incr) begin
					if (cfg.wcode == WC_BYTE1 && cfg.rcode == WC_BYTE4) begin
						state_nxt.counter = (c + 32'd4) & wm;
					end else begin
						state_nxt.counter = (c + 32'd2) & wm;
					end
				end
			end else begin
				val = incr ? c : (cfg.seed & wm);
				if (incr) begin
					state_nxt.counter = c_inc;
				end
			end
			mism = ((read_data & rm) != val);
		end
		if (!werr) begin
			state_nxt.unit_index = st.unit_index + 32'd1;
			state_nxt.fail       = st.fail | mism;
		end
	end

	// Result fields
	always_comb begin
		res.unit_address  = werr ? 32'd0 : cfg.base + (st.unit_index << ucode);
		res.pattern_value = val;
		res.mismatch      = mism;
		res.pass_failed   = state_nxt.fail;
		res.width_error   = werr;
	end

endmodule

// ===== verif/tb.sv =====
// Self-checking testbench for memory_test_pattern_engine: directed passes, then random
// write and check passes under changing widths, kinds, seeds and bases and varied backpressure.
// Depends on mtpe_pkg and the engine RTL only.
module tb;
	timeunit 1ns;
	timeprecision 1ps;

	import mtpe_pkg::*;

	localparam logic [1:0] KIND_UNUSED = 2'd3;  // decodes like the fixed pattern
	localparam int CYCLE_LIMIT = 400000;
	localparam int SETTLE_CYCLES = 4;

	typedef struct {
		logic        func;
		logic        first;
		logic        last;
		logic [31:0] rd;
	} mem_step_t;

	typedef struct {
		logic [31:0] addr;
		logic [31:0] value;
		logic        mism;
		logic        failed;
		logic        werr;
		logic        eop;
	} pattern_beat_t;

	logic        clk;
	logic        arst_n;
	logic        cfg_we;
	logic [REG_IDX_W-1:0] cfg_index;
	logic [31:0] cfg_wdata;
	logic        s_axis_tvalid;
	logic        s_axis_tready;
	logic [31:0] s_axis_tdata;   // [31:0] read_data
	logic [1:0]  s_axis_tuser;   // [0] func, [1] first_item
	logic        s_axis_tlast;   // last_item
	logic        m_axis_tvalid;
	logic        m_axis_tready;
	// [31:0] unit_address, [63:32] pattern_value, [64] mismatch,
	// [65] pass_failed, [66] width_error, [71:67] zero
	logic [71:0] m_axis_tdata;
	logic        m_axis_tlast;   // end_of_pass

	// Shadow of the register file
	logic [31:0] cfg_seed;
	logic [1:0]  cfg_kind;
	logic [1:0]  cfg_wcode;
	logic [1:0]  cfg_rcode;
	logic [31:0] cfg_base;

	// Shadow of the engine state
	logic [31:0] ptn_counter;
	logic [31:0] ptn_held;
	logic [1:0]  ptn_piece;
	logic [31:0] ptn_unit;
	logic        ptn_fail;

	pattern_beat_t expected_pattern_beats[$];
	int error_count = 0;
	int steps_sent = 0;
	int cycle_count = 0;
	int idle_pct = 0;
	int stall_pct = 0;

	memory_test_pattern_engine u_top (
		.clk(clk),
		.arst_n(arst_n),
		.cfg_we(cfg_we),
		.cfg_index(cfg_index),
		.cfg_wdata(cfg_wdata),
		.s_axis_tvalid(s_axis_tvalid),
		.s_axis_tready(s_axis_tready),
		.s_axis_tdata(s_axis_tdata),
		.s_axis_tuser(s_axis_tuser),
		.s_axis_tlast(s_axis_tlast),
		.m_axis_tvalid(m_axis_tvalid),
		.m_axis_tready(m_axis_tready),
		.m_axis_tdata(m_axis_tdata),
		.m_axis_tlast(m_axis_tlast)
	);

	initial begin
		clk = 1'b0;
		forever #6 clk = ~clk;
	end

	// Run limit
	always @(posedge clk) begin
		cycle_count++;
		if (cycle_count >= CYCLE_LIMIT) begin
			$display("Testbench completed WITH ERRORS");
			$finish;
		end
	end

	// Receiver backpressure
	always @(posedge clk) begin
		m_axis_tready <= ($urandom_range(99) >= stall_pct);
	end

	function automatic logic [31:0] bytes_mask(input logic [31:0] nbytes);
		return (nbytes >= 4) ? 32'hFFFF_FFFF : ((32'd1 << (8 * nbytes)) - 32'd1);
	endfunction

	// Expected result of one step; advances the shadow state
	function automatic pattern_beat_t next_pattern_beat(input mem_step_t s);
		pattern_beat_t beat;
		logic incr, anti, werr;
		logic [31:0] wb, wm, ub, rb, rm, c, v, cnt, k;
		int i;
		beat = '{default: '0};
		incr = (cfg_kind == KIND_INCR);
		anti = (cfg_kind == KIND_ANTI);
		beat.eop = s.last;
		if (s.first) begin
			ptn_unit = '0;
			ptn_fail = 1'b0;
			ptn_piece = '0;
			ptn_held = '0;
			ptn_counter = (cfg_wcode != WC_BAD) ?
				(cfg_seed & bytes_mask(32'd1 << cfg_wcode)) : cfg_seed;
		end
		werr = (cfg_wcode == WC_BAD) ||
			(s.func == FUNC_CHECK && !anti && cfg_rcode == WC_BAD);
		if (werr) begin
			beat.failed = ptn_fail;
			beat.werr = 1'b1;
			return beat;
		end
		wb = 32'd1 << cfg_wcode;
		wm = bytes_mask(wb);
		c = ptn_counter & wm;
		ub = wb;
		if (s.func == FUNC_WRITE) begin
			beat.value = anti ? (~c & 32'hFF) : c;
			if (incr || anti)
				ptn_counter = (c + 1) & wm;
		end else if (anti) begin
			// anti checks run at the write width, byte-truncated inverse
			beat.value = ~c & 32'hFF;
			ptn_counter = (c + 1) & wm;
			beat.mism = ((s.rd & wm) != beat.value);
		end else begin
			rb = 32'd1 << cfg_rcode;
			rm = bytes_mask(rb);
			ub = rb;
			if (wb > rb) begin
				// wide write unit read back as little-endian pieces
				cnt = wb / rb;
				if (32'(ptn_piece) >= cnt)
					ptn_piece = '0;
				if (ptn_piece == 0) begin
					ptn_held = incr ? c : (cfg_seed & wm);
					if (incr)
						ptn_counter = (c + 1) & wm;
				end
				beat.value = (ptn_held >> (32'(ptn_piece) * 8 * rb)) & rm;
				ptn_piece = (32'(ptn_piece) + 1 >= cnt) ? 2'd0 : ptn_piece + 2'd1;
			end else if (wb < rb) begin
				// narrow write units packed into one read unit
				k = rb / wb;
				for (i = 0; i < k; i++) begin
					v = (incr ? c + i : cfg_seed) & wm;
					beat.value |= v << (i * 8 * wb);
				end
				if (incr)
					ptn_counter = (c + k) & wm;
			end else begin
				beat.value = incr ? c : (cfg_seed & wm);
				if (incr)
					ptn_counter = (c + 1) & wm;
			end
			beat.mism = ((s.rd & rm) != beat.value);
		end
		beat.addr = cfg_base + ptn_unit * ub;
		ptn_unit++;
		if (beat.mism)
			ptn_fail = 1'b1;
		beat.failed = ptn_fail;
		return beat;
	endfunction

	// Pattern value a step would get, leaving the shadow state untouched
	function automatic logic [31:0] peek_pattern_value(input mem_step_t s);
		logic [31:0] c0, h0, u0;
		logic [1:0] p0;
		logic f0;
		pattern_beat_t beat;
		c0 = ptn_counter;
		h0 = ptn_held;
		u0 = ptn_unit;
		p0 = ptn_piece;
		f0 = ptn_fail;
		beat = next_pattern_beat(s);
		ptn_counter = c0;
		ptn_held = h0;
		ptn_unit = u0;
		ptn_piece = p0;
		ptn_fail = f0;
		return beat.value;
	endfunction

	function automatic void note_mismatch(input string field, input logic [31:0] want,
			input logic [31:0] got);
		error_count++;
		if (error_count <= 10)
			$display("%0t: %s mismatch: expected %h, got %h", $time, field, want, got);
	endfunction

	// Result checker
	always @(posedge clk) begin : check_results
		pattern_beat_t want;
		if (arst_n && m_axis_tvalid && m_axis_tready) begin
			if (expected_pattern_beats.size() == 0) begin
				error_count++;
				if (error_count <= 10)
					$display("%0t: result beat with nothing expected", $time);
			end else begin
				want = expected_pattern_beats.pop_front();
				if (m_axis_tdata[31:0] !== want.addr)
					note_mismatch("unit_address", want.addr, m_axis_tdata[31:0]);
				if (m_axis_tdata[63:32] !== want.value)
					note_mismatch("pattern_value", want.value, m_axis_tdata[63:32]);
				if (m_axis_tdata[64] !== want.mism)
					note_mismatch("mismatch", 32'(want.mism), 32'(m_axis_tdata[64]));
				if (m_axis_tdata[65] !== want.failed)
					note_mismatch("pass_failed", 32'(want.failed), 32'(m_axis_tdata[65]));
				if (m_axis_tdata[66] !== want.werr)
					note_mismatch("width_error", 32'(want.werr), 32'(m_axis_tdata[66]));
				if (m_axis_tdata[71:67] !== 5'd0)
					note_mismatch("padding", 32'd0, 32'(m_axis_tdata[71:67]));
				if (m_axis_tlast !== want.eop)
					note_mismatch("end_of_pass", 32'(want.eop), 32'(m_axis_tlast));
			end
		end
	end

	// One input beat; valid stays up after acceptance so back-to-back beats need no gap
	task automatic send_step(input mem_step_t s);
		while ($urandom_range(99) < idle_pct) begin
			s_axis_tvalid <= 1'b0;
			@(posedge clk);
		end
		s_axis_tvalid <= 1'b1;
		s_axis_tdata <= s.rd;
		s_axis_tuser <= {s.first, s.func};
		s_axis_tlast <= s.last;
		@(posedge clk);
		while (!s_axis_tready)
			@(posedge clk);
		expected_pattern_beats.push_back(next_pattern_beat(s));
		steps_sent++;
	endtask

	// Check steps carry the right data in the compared bytes, noise above them, and optionally one flipped bit
	task automatic run_step(input logic func, input logic first, input logic last,
			input logic corrupt, input logic [31:0] noise);
		mem_step_t s;
		logic [1:0] code;
		logic [31:0] keep;
		int bits;
		s.func = func;
		s.first = first;
		s.last = last;
		s.rd = noise;
		if (func == FUNC_CHECK) begin
			code = (cfg_kind == KIND_ANTI) ? cfg_wcode : cfg_rcode;
			bits = (code == WC_BAD) ? 32 : (8 << code);
			keep = (bits == 32) ? 32'hFFFF_FFFF : ((32'd1 << bits) - 32'd1);
			s.rd = (peek_pattern_value(s) & keep) | (noise & ~keep);
			if (corrupt)
				s.rd ^= 32'd1 << $urandom_range(bits - 1);
		end
		send_step(s);
	endtask

	task automatic drain_results();
		s_axis_tvalid <= 1'b0;
		while (expected_pattern_beats.size() != 0)
			@(posedge clk);
		repeat (SETTLE_CYCLES) @(posedge clk);
	endtask

	// Writes every register once the engine is idle
	task automatic set_config(input logic [31:0] seed, input logic [1:0] kind,
			input logic [1:0] wcode, input logic [1:0] rcode, input logic [31:0] base);
		drain_results();
		cfg_we <= 1'b1;
		cfg_index <= REG_SEED;
		cfg_wdata <= seed;
		@(posedge clk);
		cfg_index <= REG_KIND;
		cfg_wdata <= {30'd0, kind};
		@(posedge clk);
		cfg_index <= REG_WCODE;
		cfg_wdata <= {30'd0, wcode};
		@(posedge clk);
		cfg_index <= REG_RCODE;
		cfg_wdata <= {30'd0, rcode};
		@(posedge clk);
		cfg_index <= REG_BASE;
		cfg_wdata <= base;
		@(posedge clk);
		cfg_we <= 1'b0;
		cfg_seed = seed;
		cfg_kind = kind;
		cfg_wcode = wcode;
		cfg_rcode = rcode;
		cfg_base = base;
	endtask

	// Reset configuration: incrementing, 4-byte units, with a sticky check failure
	task automatic test_reset_config_passes();
		run_step(FUNC_WRITE, 1'b1, 1'b0, 1'b0, 32'hFFFF_FFFF);
		run_step(FUNC_WRITE, 1'b0, 1'b0, 1'b0, 32'h0000_0000);
		run_step(FUNC_WRITE, 1'b0, 1'b1, 1'b0, $urandom);
		run_step(FUNC_CHECK, 1'b1, 1'b0, 1'b0, 32'h0000_0000);
		run_step(FUNC_CHECK, 1'b0, 1'b0, 1'b1, $urandom);
		run_step(FUNC_CHECK, 1'b0, 1'b1, 1'b0, 32'hFFFF_FFFF);
	endtask

	// 4-byte writes read back bytewise, address wrapping past the top
	task automatic test_wide_write_split();
		set_config(32'hFFFF_FFFF, KIND_INCR, WC_BYTE4, WC_BYTE1, 32'hFFFF_FFFC);
		run_step(FUNC_CHECK, 1'b1, 1'b0, 1'b0, 32'hFFFF_FFFF);
		run_step(FUNC_CHECK, 1'b0, 1'b0, 1'b0, 32'hFFFF_FFFF);
		run_step(FUNC_CHECK, 1'b0, 1'b0, 1'b1, 32'hFFFF_FFFF);
		run_step(FUNC_CHECK, 1'b0, 1'b0, 1'b0, 32'h0000_0000);
		run_step(FUNC_CHECK, 1'b0, 1'b0, 1'b0, $urandom);
		run_step(FUNC_CHECK, 1'b0, 1'b0, 1'b0, $urandom);
	endtask

	// Read width shrinks the piece count below the current piece: restart at piece zero
	task automatic test_stale_piece_restart();
		set_config(32'hFFFF_FFFF, KIND_INCR, WC_BYTE4, WC_BYTE2, 32'hFFFF_FFFC);
		run_step(FUNC_CHECK, 1'b0, 1'b0, 1'b0, $urandom);
		run_step(FUNC_CHECK, 1'b0, 1'b1, 1'b0, $urandom);
	endtask

	// Byte writes packed into words (counter wraps at a byte), fixed pattern replicated
	task automatic test_narrow_write_pack();
		set_config(32'h0000_00FE, KIND_INCR, WC_BYTE1, WC_BYTE4, 32'h0000_0000);
		run_step(FUNC_CHECK, 1'b1, 1'b0, 1'b0, $urandom);
		run_step(FUNC_CHECK, 1'b0, 1'b1, 1'b0, $urandom);
		set_config(32'h1234_ABCD, KIND_FIXED, WC_BYTE2, WC_BYTE4, 32'h0000_1000);
		run_step(FUNC_CHECK, 1'b1, 1'b1, 1'b0, $urandom);
	endtask

	// Anti pattern keeps only the low byte and ignores a bad read width
	task automatic test_anti_pattern();
		set_config(32'hABCD_00FF, KIND_ANTI, WC_BYTE2, WC_BAD, 32'h8000_0000);
		run_step(FUNC_WRITE, 1'b1, 1'b0, 1'b0, $urandom);
		run_step(FUNC_WRITE, 1'b0, 1'b1, 1'b0, $urandom);
		run_step(FUNC_CHECK, 1'b1, 1'b0, 1'b0, 32'hFFFF_FFFF);
		run_step(FUNC_CHECK, 1'b0, 1'b1, 1'b0, 32'hFFFF_FFFF);
	endtask

	// Bad write width, bad read width on a check, unused kind code
	task automatic test_invalid_widths();
		set_config(32'hFFFF_FFFF, KIND_INCR, WC_BAD, WC_BYTE1, 32'h0000_0000);
		run_step(FUNC_WRITE, 1'b1, 1'b1, 1'b0, $urandom);
		set_config(32'h0000_005A, KIND_FIXED, WC_BYTE1, WC_BAD, 32'h0000_0000);
		run_step(FUNC_CHECK, 1'b1, 1'b1, 1'b0, $urandom);
		set_config(32'h1234_5678, KIND_UNUSED, WC_BYTE1, WC_BYTE2, 32'hFFFF_FFFF);
		run_step(FUNC_CHECK, 1'b1, 1'b1, 1'b0, $urandom);
	endtask

	function automatic logic [31:0] random_word_or_extreme();
		case ($urandom_range(3))
			0: return 32'h0000_0000;
			1: return 32'hFFFF_FFFF;
			default: return $urandom;
		endcase
	endfunction

	function automatic logic [1:0] random_width_code();
		return ($urandom_range(9) == 0) ? WC_BAD : 2'($urandom_range(2));
	endfunction

	// Mostly well-formed write then check passes, some broken ones and raw noise
	task automatic test_random_traffic(input int n_steps, input int send_idle,
			input int recv_stall);
		int start, wlen, clen, i;
		mem_step_t noise_step;
		idle_pct = send_idle;
		stall_pct = recv_stall;
		start = steps_sent;
		while (steps_sent - start < n_steps) begin
			set_config(random_word_or_extreme(), 2'($urandom_range(3)), random_width_code(),
				random_width_code(), random_word_or_extreme());
			repeat ($urandom_range(1, 3)) begin
				if ($urandom_range(99) < 82) begin
					wlen = $urandom_range(1, 24);
					clen = $urandom_range(1, 24);
					for (i = 0; i < wlen; i++)
						run_step(FUNC_WRITE, i == 0, i == wlen - 1, 1'b0, $urandom);
					// now and then the check pass skips its restart
					for (i = 0; i < clen; i++)
						run_step(FUNC_CHECK, i == 0 && $urandom_range(19) != 0, i == clen - 1,
							$urandom_range(99) < 8, $urandom);
				end else begin
					repeat ($urandom_range(4, 12)) begin
						noise_step.func = 1'($urandom_range(1));
						noise_step.first = 1'($urandom_range(1));
						noise_step.last = 1'($urandom_range(1));
						noise_step.rd = $urandom;
						send_step(noise_step);
					end
				end
			end
		end
	endtask

	initial begin
		arst_n = 1'b0;
		cfg_we = 1'b0;
		cfg_index = REG_SEED;
		cfg_wdata = '0;
		s_axis_tvalid = 1'b0;
		s_axis_tdata = '0;
		s_axis_tuser = '0;
		s_axis_tlast = 1'b0;
		cfg_seed = '0;
		cfg_kind = KIND_INCR;
		cfg_wcode = WC_BYTE4;
		cfg_rcode = WC_BYTE4;
		cfg_base = '0;
		ptn_counter = '0;
		ptn_held = '0;
		ptn_piece = '0;
		ptn_unit = '0;
		ptn_fail = 1'b0;
		repeat (10) @(posedge clk);
		arst_n <= 1'b1;
		@(posedge clk);

		test_reset_config_passes();
		test_wide_write_split();
		test_stale_piece_restart();
		test_narrow_write_pack();
		test_anti_pattern();
		test_invalid_widths();
		test_random_traffic(262, 0, 0);
		test_random_traffic(262, 86, 0);
		test_random_traffic(262, 0, 86);
		test_random_traffic(262, 38, 38);
		drain_results();

		if (error_count == 0)
			$display("Testbench completed without errors");
		else
			$display("Testbench completed WITH ERRORS");
		$finish;
	end

endmodule
